[src/rbcm_pkg.sv]
// Shared types and constants for the rainbow colormap pipeline.
`timescale 1ns / 1ps

package rbcm_pkg;

	// Position scale: 3072 is 1.0, breakpoints sit at twelfths (multiples of 256)
	localparam logic signed [15:0] PosOne = 16'sd3072;
	localparam logic signed [16:0] PosTwo = 17'sd6144;
	localparam logic signed [15:0] Bp1    = 16'sd256;
	localparam logic signed [15:0] Bp3    = 16'sd768;
	localparam logic signed [15:0] Bp5    = 16'sd1280;
	localparam logic signed [15:0] Bp7    = 16'sd1792;
	localparam logic signed [15:0] Bp9    = 16'sd2304;
	localparam logic signed [15:0] Bp11   = 16'sd2816;

	// Slope coefficients, applied as (coef * x) >> 9
	localparam logic [7:0] CoefRed     = 8'd255;
	localparam logic [7:0] CoefGreenUp = 8'd165;
	localparam logic [7:0] CoefGreenLo = 8'd90;
	localparam logic [7:0] CoefGreenHi = 8'd128;
	localparam logic [7:0] CoefGreenDn = 8'd127;
	localparam logic [7:0] CoefBlue    = 8'd255;

	localparam logic [7:0]  ChanMax   = 8'd255;
	localparam int unsigned FracBits  = 9;
	localparam logic [17:0] RoundUp   = 18'd511;

	// How a channel value is formed from its slope term
	typedef enum logic [1:0] {
		MODE_ZERO = 2'd0,  // constant 0
		MODE_FULL = 2'd1,  // constant 255
		MODE_LIN  = 2'd2,  // truncated slope term
		MODE_INV  = 2'd3   // 255 minus rounded-up slope term
	} rbcm_mode_t;

	typedef struct packed {
		rbcm_mode_t  mode;
		logic [7:0]  coef;
		logic [9:0]  x;
	} rbcm_chan_t;

	typedef struct packed {
		rbcm_mode_t  mode;
		logic [16:0] sum;
	} rbcm_prod_t;

endpackage

[src/rainbow_colormap_unit.sv]
// Top level: four-stage pipeline mapping a position to an RGB rainbow color.
`timescale 1ns / 1ps

// Maps a signed 16-bit position (3072 = 1.0, positions above 1.0 fold back as
// 2.0 minus the position) to 8-bit red, green and blue along a piecewise linear
// red-to-blue rainbow. One beat is accepted every clock while the output does
// not stall, and each result passes four register stages in order: fold,
// segment decode, slope multiply, output register. Backpressure on the output
// stalls only the occupied stages; in_ready is high whenever stage one is empty
// or can move forward in the same cycle. No state other than the pipeline.
module rainbow_colormap_unit (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [15:0] position,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [7:0]         red,
	output logic [7:0]         green,
	output logic [7:0]         blue
);

	logic v_s1, v_s2, v_s3, v_s4;
	logic rdy_s1, rdy_s2, rdy_s3, rdy_s4;

	logic signed [15:0] p_s1;
	rbcm_pkg::rbcm_chan_t red_c_s2, green_c_s2, blue_c_s2;
	rbcm_pkg::rbcm_prod_t red_p_s3, green_p_s3, blue_p_s3;
	logic [7:0] red_s4, green_s4, blue_s4;

	logic signed [15:0] p_fold;
	rbcm_pkg::rbcm_chan_t red_c, green_c, blue_c;
	rbcm_pkg::rbcm_prod_t red_p, green_p, blue_p;
	logic [7:0] red_o, green_o, blue_o;

	// Stage advance: a stage takes a new beat when empty or when it drains
	assign rdy_s4   = !v_s4 || out_ready;
	assign rdy_s3   = !v_s3 || rdy_s4;
	assign rdy_s2   = !v_s2 || rdy_s3;
	assign rdy_s1   = !v_s1 || rdy_s2;
	assign in_ready = rdy_s1;

	// Fold positions above 1.0 back as 2.0 minus position
	always_comb begin
		if (position > rbcm_pkg::PosOne) begin
			p_fold = 16'(rbcm_pkg::PosTwo - 17'(position));
		end else begin
			p_fold = position;
		end
	end

	// Pick each channel's segment and its distance from the breakpoint
	always_comb begin
		red_c   = '{mode: rbcm_pkg::MODE_ZERO, coef: '0, x: '0};
		green_c = '{mode: rbcm_pkg::MODE_ZERO, coef: '0, x: '0};
		blue_c  = '{mode: rbcm_pkg::MODE_ZERO, coef: '0, x: '0};

		if (p_s1 < rbcm_pkg::Bp5) begin
			red_c.mode = rbcm_pkg::MODE_FULL;
		end else if (p_s1 < rbcm_pkg::Bp7) begin
			red_c.mode = rbcm_pkg::MODE_LIN;
			red_c.coef = rbcm_pkg::CoefRed;
			red_c.x    = 10'(rbcm_pkg::Bp7 - p_s1);
		end

		if (p_s1 < rbcm_pkg::Bp1) begin
			green_c.mode = rbcm_pkg::MODE_ZERO;
		end else if (p_s1 < rbcm_pkg::Bp3) begin
			green_c.mode = rbcm_pkg::MODE_LIN;
			green_c.coef = rbcm_pkg::CoefGreenUp;
			green_c.x    = 10'(p_s1 - rbcm_pkg::Bp1);
		end else if (p_s1 < rbcm_pkg::Bp5) begin
			green_c.mode = rbcm_pkg::MODE_INV;
			green_c.coef = rbcm_pkg::CoefGreenLo;
			green_c.x    = 10'(rbcm_pkg::Bp5 - p_s1);
		end else if (p_s1 < rbcm_pkg::Bp7) begin
			green_c.mode = rbcm_pkg::MODE_FULL;
		end else if (p_s1 < rbcm_pkg::Bp9) begin
			green_c.mode = rbcm_pkg::MODE_INV;
			green_c.coef = rbcm_pkg::CoefGreenHi;
			green_c.x    = 10'(p_s1 - rbcm_pkg::Bp7);
		end else if (p_s1 < rbcm_pkg::Bp11) begin
			green_c.mode = rbcm_pkg::MODE_LIN;
			green_c.coef = rbcm_pkg::CoefGreenDn;
			green_c.x    = 10'(rbcm_pkg::Bp11 - p_s1);
		end

		if (p_s1 < rbcm_pkg::Bp7) begin
			blue_c.mode = rbcm_pkg::MODE_ZERO;
		end else if (p_s1 < rbcm_pkg::Bp9) begin
			blue_c.mode = rbcm_pkg::MODE_LIN;
			blue_c.coef = rbcm_pkg::CoefBlue;
			blue_c.x    = 10'(p_s1 - rbcm_pkg::Bp7);
		end else begin
			blue_c.mode = rbcm_pkg::MODE_FULL;
		end
	end

	// Multiply by the slope; add the round-up bias on the MODE_INV green segments
	function automatic rbcm_pkg::rbcm_prod_t slope_mul(input rbcm_pkg::rbcm_chan_t c);
		rbcm_pkg::rbcm_prod_t r;
		logic [17:0] prod;
		prod   = 18'(c.coef) * 18'(c.x);
		r.mode = c.mode;
		if (c.mode == rbcm_pkg::MODE_INV) begin
			r.sum = 17'(prod + rbcm_pkg::RoundUp);
		end else begin
			r.sum = 17'(prod);
		end
		return r;
	endfunction

	assign red_p   = slope_mul(red_c_s2);
	assign green_p = slope_mul(green_c_s2);
	assign blue_p  = slope_mul(blue_c_s2);

	// Shift out the fraction and form the channel value
	function automatic logic [7:0] chan_out(input rbcm_pkg::rbcm_prod_t pr);
		logic [7:0] term;
		logic [7:0] v;
		term = pr.sum[rbcm_pkg::FracBits +: 8];
		case (pr.mode)
			rbcm_pkg::MODE_ZERO: v = '0;
			rbcm_pkg::MODE_FULL: v = rbcm_pkg::ChanMax;
			rbcm_pkg::MODE_LIN:  v = term;
			rbcm_pkg::MODE_INV:  v = rbcm_pkg::ChanMax - term;
			default:             v = '0;
		endcase
		return v;
	endfunction

	assign red_o   = chan_out(red_p_s3);
	assign green_o = chan_out(green_p_s3);
	assign blue_o  = chan_out(blue_p_s3);

	// Valid bits travel with the beats
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (rdy_s1) v_s1 <= in_valid;
			if (rdy_s2) v_s2 <= v_s1;
			if (rdy_s3) v_s3 <= v_s2;
			if (rdy_s4) v_s4 <= v_s3;
		end
	end

	// Payload registers: load on advance, hold while stalled
	always_ff @(posedge clk) begin
		if (in_valid && rdy_s1) begin
			p_s1 <= p_fold;
		end
		if (v_s1 && rdy_s2) begin
			red_c_s2   <= red_c;
			green_c_s2 <= green_c;
			blue_c_s2  <= blue_c;
		end
		if (v_s2 && rdy_s3) begin
			red_p_s3   <= red_p;
			green_p_s3 <= green_p;
			blue_p_s3  <= blue_p;
		end
		if (v_s3 && rdy_s4) begin
			red_s4   <= red_o;
			green_s4 <= green_o;
			blue_s4  <= blue_o;
		end
	end

	assign out_valid = v_s4;
	assign red       = red_s4;
	assign green     = green_s4;
	assign blue      = blue_s4;

endmodule

[src/rbcm_checker.sv]
// Port-level checker for the rainbow colormap unit, bound to the top level.
`timescale 1ns / 1ps

module rbcm_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_ready,
	input logic signed [15:0] position,
	input logic               out_valid,
	input logic               out_ready,
	input logic [7:0]         red,
	input logic [7:0]         green,
	input logic [7:0]         blue
);

	// Hold a waiting input beat and its position
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_ready |=> in_valid && $stable(position))
		else $error("input beat changed while waiting");

	// Hold a stalled result beat
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result beat dropped while stalled");

	// Keep a stalled result's payload
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(red) && $stable(green) && $stable(blue))
		else $error("result payload changed while stalled");

	// Red and blue ramps never overlap
	a_red_blue: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> red == 8'd0 || blue == 8'd0)
		else $error("red and blue both lit");

	// Full green only on the plateau, where blue is still dark
	a_green_plateau: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && green == 8'd255 |-> blue == 8'd0)
		else $error("full green with blue lit");

endmodule

bind rainbow_colormap_unit rbcm_checker u_rbcm_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.position  (position),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.red       (red),
	.green     (green),
	.blue      (blue)
);
